### sv/ktsi_pkg.sv
// Shared types and constants for the keyed table block.
// Used by ktsi_ctrl and keyed_table_search_insert_remove; no dependencies.
`default_nettype none

package ktsi_pkg;

    localparam int DEPTH_DEFAULT = 64;

    localparam int KEY_W   = 32;
    localparam int PAY_W   = 32;
    localparam int ENTRY_W = KEY_W + PAY_W;
    localparam int POS_W   = 7;
    localparam int CAP_W   = 7;
    localparam int MODE_W  = 2;
    localparam int CFG_IDX_W = 1;

    // request operation codes
    localparam logic [MODE_W-1:0] OP_SEARCH = 2'd0;
    localparam logic [MODE_W-1:0] OP_INSERT = 2'd1;
    localparam logic [MODE_W-1:0] OP_REMOVE = 2'd2;
    localparam logic [MODE_W-1:0] OP_NONE   = 2'd3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ORDERED  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY = 1'b1;

    localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

    typedef struct packed {
        logic [MODE_W-1:0]       mode;
        logic signed [KEY_W-1:0] key;
        logic [PAY_W-1:0]        payload;
    } req_t;

    typedef struct packed {
        logic             ok;
        logic             found;
        logic [POS_W-1:0] position;
        logic [POS_W-1:0] entry_count;
        logic [PAY_W-1:0] read_payload;
    } rsp_t;

    typedef struct packed {
        logic             ordered;
        logic [CAP_W-1:0] capacity;
    } cfg_t;

endpackage

`default_nettype wire

### sv/ktsi_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module ktsi_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output      logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

### sv/ktsi_ctrl.sv
// Sequencer for the keyed table: binary search, linear scan and entry moves,
// all through the single read and write port of the table RAM.
// Depends on ktsi_pkg.
`default_nettype none

module ktsi_ctrl #(
    parameter int TABLE_DEPTH = ktsi_pkg::DEPTH_DEFAULT
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire ktsi_pkg::cfg_t                 cfg,
    input  wire logic                           req_valid,
    output      logic                           req_ready,
    input  wire ktsi_pkg::req_t                 req,
    output      logic                           res_valid,
    input  wire logic                           res_ready,
    output      ktsi_pkg::rsp_t                 res,
    output      logic [$clog2(TABLE_DEPTH)-1:0] ram_rd_addr,
    input  wire logic [ktsi_pkg::ENTRY_W-1:0]   ram_rd_data,
    output      logic                           ram_wr_en,
    output      logic [$clog2(TABLE_DEPTH)-1:0] ram_wr_addr,
    output      logic [ktsi_pkg::ENTRY_W-1:0]   ram_wr_data
);

    import ktsi_pkg::*;

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(TABLE_DEPTH);
    localparam logic [CNT_W-1:0] ONE_CNT   = CNT_W'(1);
    localparam logic [IDX_W-1:0] ONE_IDX   = IDX_W'(1);

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_BIN  = 4'd1;
    localparam logic [3:0] ST_BCMP = 4'd2;
    localparam logic [3:0] ST_CHK  = 4'd3;
    localparam logic [3:0] ST_CCMP = 4'd4;
    localparam logic [3:0] ST_LIN  = 4'd5;
    localparam logic [3:0] ST_ACT  = 4'd6;
    localparam logic [3:0] ST_MOVE = 4'd7;
    localparam logic [3:0] ST_PUT  = 4'd8;
    localparam logic [3:0] ST_DONE = 4'd9;

    logic [3:0]              state_reg,    state_next;
    logic [MODE_W-1:0]       op_reg,       op_next;
    logic signed [KEY_W-1:0] key_reg,      key_next;
    logic [PAY_W-1:0]        pay_reg,      pay_next;
    logic [CNT_W-1:0]        lo_reg,       lo_next;
    logic [CNT_W-1:0]        hi_reg,       hi_next;
    logic [IDX_W-1:0]        mid_reg,      mid_next;
    logic [CNT_W-1:0]        pos_reg,      pos_next;
    logic                    found_reg,    found_next;
    logic                    ok_reg,       ok_next;
    logic [PAY_W-1:0]        rdpay_reg,    rdpay_next;
    logic [CNT_W-1:0]        count_reg,    count_next;
    logic [CNT_W-1:0]        scan_reg,     scan_next;
    logic                    pend_reg,     pend_next;
    logic [IDX_W-1:0]        pend_idx_reg, pend_idx_next;
    logic [IDX_W-1:0]        src_reg,      src_next;
    logic [IDX_W-1:0]        dst_reg,      dst_next;
    logic [CNT_W-1:0]        n_reg,        n_next;
    logic                    dec_reg,      dec_next;
    logic                    wpend_reg,    wpend_next;
    logic [IDX_W-1:0]        waddr_reg,    waddr_next;

    logic signed [KEY_W-1:0] rd_key;
    logic [PAY_W-1:0]        rd_pay;
    logic                    key_lt;
    logic                    key_eq;
    logic [CNT_W:0]          mid_sum;
    logic                    full;

    assign rd_key = $signed(ram_rd_data[ENTRY_W-1:PAY_W]);
    assign rd_pay = ram_rd_data[PAY_W-1:0];

    // shared key comparator
    assign key_lt = rd_key < key_reg;
    assign key_eq = rd_key == key_reg;

    assign mid_sum = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign full    = (CMP_W'(count_reg) >= CMP_W'(cfg.capacity)) || (count_reg == DEPTH_CNT);

    assign res.ok           = ok_reg;
    assign res.found        = found_reg;
    assign res.position     = POS_W'(pos_reg);
    assign res.entry_count  = POS_W'(count_reg);
    assign res.read_payload = rdpay_reg;

    always_comb
    begin
        state_next    = state_reg;
        op_next       = op_reg;
        key_next      = key_reg;
        pay_next      = pay_reg;
        lo_next       = lo_reg;
        hi_next       = hi_reg;
        mid_next      = mid_reg;
        pos_next      = pos_reg;
        found_next    = found_reg;
        ok_next       = ok_reg;
        rdpay_next    = rdpay_reg;
        count_next    = count_reg;
        scan_next     = scan_reg;
        pend_next     = pend_reg;
        pend_idx_next = pend_idx_reg;
        src_next      = src_reg;
        dst_next      = dst_reg;
        n_next        = n_reg;
        dec_next      = dec_reg;
        wpend_next    = 1'b0;
        waddr_next    = waddr_reg;
        req_ready     = 1'b0;
        res_valid     = 1'b0;
        ram_rd_addr   = src_reg;
        ram_wr_en     = 1'b0;
        ram_wr_addr   = waddr_reg;
        ram_wr_data   = ram_rd_data;

        unique case (state_reg)
            ST_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    op_next    = req.mode;
                    key_next   = req.key;
                    pay_next   = req.payload;
                    found_next = 1'b0;
                    ok_next    = 1'b0;
                    rdpay_next = '0;
                    lo_next    = '0;
                    hi_next    = count_reg;
                    scan_next  = '0;
                    pend_next  = 1'b0;
                    if (req.mode == OP_NONE)
                    begin
                        pos_next   = '0;
                        state_next = ST_DONE;
                    end
                    else if (cfg.ordered)
                    begin
                        state_next = ST_BIN;
                    end
                    else
                    begin
                        state_next = ST_LIN;
                    end
                end
            end

            ST_BIN:
            begin
                // issue the probe at the middle of the open range
                mid_next    = IDX_W'(mid_sum[CNT_W:1]);
                ram_rd_addr = IDX_W'(mid_sum[CNT_W:1]);
                if (lo_reg == hi_reg)
                begin
                    pos_next   = lo_reg;
                    state_next = ST_CHK;
                end
                else
                begin
                    state_next = ST_BCMP;
                end
            end

            ST_BCMP:
            begin
                priority if (key_eq)
                begin
                    pos_next   = CNT_W'(mid_reg);
                    state_next = ST_CHK;
                end
                else if (key_lt)
                begin
                    lo_next    = CNT_W'(mid_reg) + ONE_CNT;
                    state_next = ST_BIN;
                end
                else
                begin
                    hi_next    = CNT_W'(mid_reg);
                    state_next = ST_BIN;
                end
            end

            ST_CHK:
            begin
                ram_rd_addr = IDX_W'(pos_reg);
                if (pos_reg < count_reg)
                begin
                    state_next = ST_CCMP;
                end
                else
                begin
                    found_next = 1'b0;
                    state_next = ST_ACT;
                end
            end

            ST_CCMP:
            begin
                found_next = key_eq;
                rdpay_next = rd_pay;
                state_next = ST_ACT;
            end

            ST_LIN:
            begin
                // one read issued and one compared per cycle
                ram_rd_addr = IDX_W'(scan_reg);
                priority if (pend_reg && key_eq)
                begin
                    pos_next   = CNT_W'(pend_idx_reg);
                    found_next = 1'b1;
                    rdpay_next = rd_pay;
                    state_next = ST_ACT;
                end
                else if (!pend_reg && (scan_reg == count_reg))
                begin
                    pos_next   = count_reg;
                    found_next = 1'b0;
                    state_next = ST_ACT;
                end
                else if (scan_reg < count_reg)
                begin
                    pend_next     = 1'b1;
                    pend_idx_next = IDX_W'(scan_reg);
                    scan_next     = scan_reg + ONE_CNT;
                end
                else
                begin
                    pend_next = 1'b0;
                end
            end

            ST_ACT:
            begin
                priority if (op_reg == OP_SEARCH)
                begin
                    ok_next = found_reg;
                    if (!found_reg)
                    begin
                        rdpay_next = '0;
                    end
                    state_next = ST_DONE;
                end
                else if (op_reg == OP_INSERT)
                begin
                    rdpay_next = '0;
                    if (!found_reg && !full)
                    begin
                        // open a gap (ordered mode only): move entries pos..count-1 up by one, top first
                        ok_next    = 1'b1;
                        n_next     = cfg.ordered ? (count_reg - pos_reg) : '0;
                        src_next   = IDX_W'(count_reg - ONE_CNT);
                        dst_next   = IDX_W'(count_reg);
                        dec_next   = 1'b1;
                        state_next = ST_MOVE;
                    end
                    else
                    begin
                        ok_next    = 1'b0;
                        state_next = ST_DONE;
                    end
                end
                else
                begin
                    rdpay_next = '0;
                    if (found_reg)
                    begin
                        ok_next    = 1'b1;
                        count_next = count_reg - ONE_CNT;
                        dec_next   = 1'b0;
                        dst_next   = IDX_W'(pos_reg);
                        if (cfg.ordered)
                        begin
                            // close the gap: move entries above pos down by one
                            n_next   = count_reg - ONE_CNT - pos_reg;
                            src_next = IDX_W'(pos_reg + ONE_CNT);
                        end
                        else
                        begin
                            // fill the hole with the last entry
                            n_next   = ONE_CNT;
                            src_next = IDX_W'(count_reg - ONE_CNT);
                        end
                        state_next = ST_MOVE;
                    end
                    else
                    begin
                        ok_next    = 1'b0;
                        state_next = ST_DONE;
                    end
                end
            end

            ST_MOVE:
            begin
                ram_rd_addr = src_reg;
                if (wpend_reg)
                begin
                    ram_wr_en   = 1'b1;
                    ram_wr_addr = waddr_reg;
                    ram_wr_data = ram_rd_data;
                end
                if (n_reg != '0)
                begin
                    n_next     = n_reg - ONE_CNT;
                    wpend_next = 1'b1;
                    waddr_next = dst_reg;
                    src_next   = dec_reg ? (src_reg - ONE_IDX) : (src_reg + ONE_IDX);
                    dst_next   = dec_reg ? (dst_reg - ONE_IDX) : (dst_reg + ONE_IDX);
                end
                else if (!wpend_reg)
                begin
                    state_next = (op_reg == OP_INSERT) ? ST_PUT : ST_DONE;
                end
            end

            ST_PUT:
            begin
                ram_wr_en   = 1'b1;
                ram_wr_addr = IDX_W'(pos_reg);
                ram_wr_data = {key_reg, pay_reg};
                count_next  = count_reg + ONE_CNT;
                state_next  = ST_DONE;
            end

            ST_DONE:
            begin
                res_valid = 1'b1;
                if (res_ready)
                begin
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            wpend_reg <= 1'b0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            wpend_reg <= wpend_next;
            pend_reg  <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        key_reg      <= key_next;
        pay_reg      <= pay_next;
        lo_reg       <= lo_next;
        hi_reg       <= hi_next;
        mid_reg      <= mid_next;
        pos_reg      <= pos_next;
        found_reg    <= found_next;
        ok_reg       <= ok_next;
        rdpay_reg    <= rdpay_next;
        scan_reg     <= scan_next;
        pend_idx_reg <= pend_idx_next;
        src_reg      <= src_next;
        dst_reg      <= dst_next;
        n_reg        <= n_next;
        dec_reg      <= dec_next;
        waddr_reg    <= waddr_next;
    end

endmodule

`default_nettype wire

### sv/keyed_table_search_insert_remove.sv
// Keyed table with search, insert and remove: top level.
// Holds the configuration registers, the table RAM and the result register.
// Depends on ktsi_pkg, ktsi_ram and ktsi_ctrl.
//
// Usage:
//  - Requests arrive on req_valid/req_ready with a ktsi_pkg::req_t payload
//    (mode, key, payload); results leave on rsp_valid/rsp_ready as rsp_t.
//    One transfer in gives exactly one transfer out, in order.
//  - One request is worked on at a time. Every table access goes through the
//    single read and write port of one RAM holding key and payload side by side.
//  - Ordered lookup: each binary search probe issues a read (ST_BIN) and then
//    compares the key (ST_BCMP); a final check reads and compares the entry
//    at the found position. Unordered lookup: a scan of one entry per cycle.
//  - Moves copy entries one at a time through the RAM port, and an insert
//    then writes the new entry. The sequencer returns to idle as the result
//    lands and takes the next request from there.
//  - The result is held in an output register; a new request is taken while
//    it waits. When the receiver stalls, a finished result is held inside the
//    sequencer until the register frees, and no further request is taken.
//  - Reset empties the table (entry count zero), sets ordered mode and a
//    capacity limit of 64. The RAM itself is not cleared: only entries below
//    the entry count are used, each written first; no clearing pass is needed.
//  - cfg_we writes cfg_data into register cfg_index in the same cycle; write
//    only while no request is in flight.
`default_nettype none

module keyed_table_search_insert_remove #(
    parameter int TABLE_DEPTH = ktsi_pkg::DEPTH_DEFAULT
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             req_valid,
    output      logic                             req_ready,
    input  wire ktsi_pkg::req_t                   req,
    output      logic                             rsp_valid,
    input  wire logic                             rsp_ready,
    output      ktsi_pkg::rsp_t                   rsp,
    input  wire logic                             cfg_we,
    input  wire logic [ktsi_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [ktsi_pkg::CAP_W-1:0]       cfg_data
);

    import ktsi_pkg::*;

    localparam int IDX_W = $clog2(TABLE_DEPTH);

    logic             ordered_reg,  ordered_next;
    logic [CAP_W-1:0] cap_reg,      cap_next;
    logic             rsp_valid_reg, rsp_valid_next;
    rsp_t             rsp_reg,      rsp_next;

    cfg_t             cfg;
    logic             res_valid;
    logic             res_ready;
    rsp_t             res;

    logic [IDX_W-1:0]   ram_rd_addr;
    logic [ENTRY_W-1:0] ram_rd_data;
    logic               ram_wr_en;
    logic [IDX_W-1:0]   ram_wr_addr;
    logic [ENTRY_W-1:0] ram_wr_data;

    // Configuration registers: plain writes, no read-back.
    always_comb
    begin
        ordered_next = ordered_reg;
        cap_next     = cap_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_ORDERED:  ordered_next = cfg_data[0];
                CFG_CAPACITY: cap_next     = cfg_data;
                default:      cap_next     = cap_reg;
            endcase
        end
    end

    assign cfg.ordered  = ordered_reg;
    assign cfg.capacity = cap_reg;

    // Result register: load when empty or being drained this cycle.
    assign res_ready = !rsp_valid_reg || rsp_ready;

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        rsp_next       = rsp_reg;
        if (res_valid && res_ready)
        begin
            rsp_valid_next = 1'b1;
            rsp_next       = res;
        end
        else if (rsp_ready)
        begin
            // drop the result once transferred
            rsp_valid_next = 1'b0;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ordered_reg   <= 1'b1;
            cap_reg       <= CAP_RESET;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            ordered_reg   <= ordered_next;
            cap_reg       <= cap_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

    // Table storage: key in the upper half of each word, payload in the lower.
    ktsi_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // Search, move and update sequencer.
    ktsi_ctrl #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .req_valid   (req_valid),
        .req_ready   (req_ready),
        .req         (req),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res         (res),
        .ram_rd_addr (ram_rd_addr),
        .ram_rd_data (ram_rd_data),
        .ram_wr_en   (ram_wr_en),
        .ram_wr_addr (ram_wr_addr),
        .ram_wr_data (ram_wr_data)
    );

endmodule

`default_nettype wire
